/* hw/rtl/tnf_pkg.sv */
// Package for the telnet NVT byte filter: byte codes, option flag positions,
// the per-step result struct and the option lookup. No dependencies.
`default_nettype none

package tnf_pkg;

  localparam logic [7:0] BYTE_IAC  = 8'hFF;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] CMD_WILL  = 8'd251;
  localparam logic [7:0] CMD_DONT  = 8'd254;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_TSPEED = 8'd32;
  localparam logic [7:0] OPT_XDISP  = 8'd35;
  localparam logic [7:0] OPT_NEWENV = 8'd39;

  localparam int unsigned F_CBIN   = 0;
  localparam int unsigned F_TTYPE  = 1;
  localparam int unsigned F_TSPEED = 2;
  localparam int unsigned F_XDISP  = 3;
  localparam int unsigned F_NEWENV = 4;
  localparam int unsigned F_CSGA   = 5;
  localparam int unsigned F_SBIN   = 6;
  localparam int unsigned F_SSGA   = 7;

  localparam logic DIR_RX = 1'b0;
  localparam logic DIR_TX = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_dir;
    logic       last;
    logic [7:0] option_flags;
  } tnf_res_t;

  typedef struct packed {
    logic [1:0] count;
    tnf_res_t   first;
    tnf_res_t   second;
  } tnf_step_t;

  // flag for options handled on the client will/wont path, zero otherwise
  function automatic logic [7:0] client_flag(logic [7:0] opt);
    logic [7:0] f;
    f = 8'h00;
    unique case (opt)
      OPT_BINARY: f[F_CBIN]   = 1'b1;
      OPT_TTYPE:  f[F_TTYPE]  = 1'b1;
      OPT_TSPEED: f[F_TSPEED] = 1'b1;
      OPT_XDISP:  f[F_XDISP]  = 1'b1;
      OPT_NEWENV: f[F_NEWENV] = 1'b1;
      default:    f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tnf_if.sv */
// Valid/ready channel interfaces for the telnet NVT byte filter.
// Input channel carries op and data_byte; output channel carries a result byte.
`default_nettype none

interface tnf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface tnf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_dir;
  logic       last;
  logic [7:0] option_flags;

  modport source (output valid, output out_byte, output out_dir, output last,
                  output option_flags, input ready);
  modport sink   (input valid, input out_byte, input out_dir, input last,
                  input option_flags, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tnf_parser.sv */
// Receive IAC parser, option flag state and transmit line discipline.
// Produces up to two results per accepted transaction. Depends on tnf_pkg.
`default_nettype none

module tnf_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              op_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              line_disc_i,
  output tnf_pkg::tnf_step_t     step_o
);
  import tnf_pkg::*;

  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_IAC  = 2'd1,
    PH_OPT  = 2'd2,
    PH_SKIP = 2'd3
  } rx_phase_e;

  typedef enum logic [1:0] {
    C_WILL = 2'd0,
    C_WONT = 2'd1,
    C_DO   = 2'd2,
    C_DONT = 2'd3
  } cmd_e;

  rx_phase_e  phase_q, phase_d;
  cmd_e       cmd_q, cmd_d;
  logic [7:0] flags_q, flags_d;

  function automatic logic [7:0] apply_option(cmd_e cmd, logic [7:0] opt,
                                              logic [7:0] fl);
    logic [7:0] f;
    logic [7:0] cf_nobin;
    f = fl;
    cf_nobin = (opt == OPT_BINARY) ? 8'h00 : client_flag(opt);
    unique case (cmd)
      C_WILL: begin
        if (opt == OPT_SGA) f[F_CSGA] = 1'b1;
        else f = f | client_flag(opt);
      end
      C_WONT: f = f & ~client_flag(opt);
      C_DO: begin
        if (opt == OPT_BINARY) f[F_SBIN] = 1'b1;
        else if (opt == OPT_SGA) begin
          f[F_SSGA] = 1'b1;
          f[F_CSGA] = 1'b1;
        end else f = f & ~cf_nobin;
      end
      C_DONT: begin
        if (opt == OPT_BINARY) f[F_SBIN] = 1'b0;
        else f = f & ~cf_nobin;
      end
      default: f = fl;
    endcase
    return f;
  endfunction

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    flags_d = flags_q;
    step_o.count           = 2'd0;
    step_o.first.out_byte  = data_byte_i;
    step_o.second.out_byte = data_byte_i;
    if (op_i) begin
      step_o.count = 2'd1;
      if (line_disc_i && data_byte_i == BYTE_IAC) begin
        step_o.count           = 2'd2;
        step_o.first.out_byte  = BYTE_IAC;
        step_o.second.out_byte = BYTE_IAC;
      end else if (line_disc_i && data_byte_i == BYTE_LF && !flags_q[F_SBIN]) begin
        step_o.count           = 2'd2;
        step_o.first.out_byte  = BYTE_CR;
        step_o.second.out_byte = BYTE_LF;
      end
    end else begin
      unique case (phase_q)
        PH_DATA: begin
          if (data_byte_i == BYTE_IAC) phase_d = PH_IAC;
          else step_o.count = 2'd1;
        end
        PH_IAC: begin
          if (data_byte_i == BYTE_IAC) begin
            phase_d      = PH_DATA;
            step_o.count = 2'd1;
          end else if (data_byte_i >= CMD_WILL && data_byte_i <= CMD_DONT) begin
            cmd_d   = cmd_e'(data_byte_i[1:0] + 2'd1);
            phase_d = PH_OPT;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_OPT: begin
          flags_d = apply_option(cmd_q, data_byte_i, flags_q);
          phase_d = PH_DATA;
        end
        PH_SKIP: phase_d = PH_DATA;
        default: phase_d = PH_DATA;
      endcase
    end
    step_o.first.out_dir       = op_i ? DIR_TX : DIR_RX;
    step_o.second.out_dir      = op_i ? DIR_TX : DIR_RX;
    step_o.first.last          = (step_o.count == 2'd1);
    step_o.second.last         = 1'b1;
    step_o.first.option_flags  = flags_d;
    step_o.second.option_flags = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DATA;
      cmd_q   <= C_WILL;
      flags_q <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/telnet_nvt_byte_filter_core.sv */
// Telnet NVT byte filter top level: config register, parser, output stage.
// Depends on tnf_pkg, tnf_if and tnf_parser.
// A result is registered and valid in the cycle after its input is accepted.
// Throughput: one byte per cycle while the output is ready; a byte that
// expands to two stalls the input until the hold register has drained.
// Reset: parser idle, option flags clear, line discipline on, output empty.
`default_nettype none

module telnet_nvt_byte_filter_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  tnf_in_if.sink    in_i,
  tnf_out_if.source out_o
);
  import tnf_pkg::*;

  logic      ld_q;
  logic      accept;
  logic      take;
  tnf_step_t step;

  logic      out_vld_q, out_vld_d;
  logic      hold_vld_q, hold_vld_d;
  tnf_res_t  out_q, out_d;
  tnf_res_t  hold_q, hold_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q <= 1'b1;
    end else if (cfg_we_i) begin
      ld_q <= cfg_wdata_i;
    end
  end

  assign take       = out_vld_q & out_o.ready;
  assign in_i.ready = !hold_vld_q && (!out_vld_q || out_o.ready);
  assign accept     = in_i.valid & in_i.ready;

  tnf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (in_i.op),
    .data_byte_i (in_i.data_byte),
    .line_disc_i (ld_q),
    .step_o      (step)
  );

  always_comb begin
    out_vld_d  = out_vld_q & ~take;
    hold_vld_d = hold_vld_q;
    out_d      = out_q;
    hold_d     = hold_q;
    if (hold_vld_q && take) begin
      out_vld_d  = 1'b1;
      out_d      = hold_q;
      hold_vld_d = 1'b0;
    end else if (accept && step.count != 2'd0) begin
      out_vld_d = 1'b1;
      out_d     = step.first;
      if (step.count == 2'd2) begin
        hold_vld_d = 1'b1;
        hold_d     = step.second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.out_byte     = out_q.out_byte;
  assign out_o.out_dir      = out_q.out_dir;
  assign out_o.last         = out_q.last;
  assign out_o.option_flags = out_q.option_flags;

endmodule

`default_nettype wire
